// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL, included by vlmr_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/vlmr_pkg.sv =====
package vlmr_pkg;

   localparam int BUFFER_BYTES = 1024;
   localparam int HEADER_BYTES = 2;
   localparam int MAX_MESSAGE  = 64;

   localparam int PTR_W  = $clog2(BUFFER_BYTES);
   localparam int USED_W = $clog2(BUFFER_BYTES + 1);
   localparam int ADV_W  = $clog2(HEADER_BYTES + MAX_MESSAGE + 1);
   localparam int CMP_W  = (USED_W > ADV_W) ? USED_W : ADV_W;
   localparam int HIDX_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

   localparam int OP_W   = 2;
   localparam int LEN_W  = 7;
   localparam int BYTE_W = 8;
   localparam int STAT_W = 3;
   localparam int SEQ_W  = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
   localparam logic [OP_W-1:0] OP_GET   = 2'd2;

   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_BYTE   = 2'd1;
   localparam logic [1:0] CMD_GET    = 2'd2;
   localparam logic [1:0] CMD_REJECT = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STAT_W-1:0] STAT_NO_SPACE = 3'd1;
   localparam logic [STAT_W-1:0] STAT_NO_OPEN  = 3'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd3;
   localparam logic [STAT_W-1:0] STAT_TOO_LONG = 3'd4;

   typedef struct packed {
      logic [1:0]        kind;
      logic [LEN_W-1:0]  arg;
      logic [BYTE_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              last;
      logic [LEN_W-1:0]  head_length;
      logic [SEQ_W-1:0]  msg_seq;
   } rsp_type;

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W:0]   n);
      logic [PTR_W+1:0] s;
      s = {2'b00, p} + {1'b0, n};
      if (s >= (PTR_W+2)'(BUFFER_BYTES)) begin
         s = s - (PTR_W+2)'(BUFFER_BYTES);
      end
      return s[PTR_W-1:0];
   endfunction

endpackage

// ===== design/vlmr_ram.sv =====
module vlmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/vlmr_front.sv =====
module vlmr_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [vlmr_pkg::OP_W-1:0]   req_op,
   input  logic [vlmr_pkg::LEN_W-1:0]  req_msg_length,
   input  logic [vlmr_pkg::BYTE_W-1:0] req_in_byte,
   input  logic [vlmr_pkg::LEN_W-1:0]  req_max_len,
   output logic                      cmd_valid,
   output vlmr_pkg::cmd_type         cmd,
   input  logic                      cmd_pop
);
   import vlmr_pkg::*;

   cmd_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   cmd_type           classified;

   assign busy      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      classified.arg  = (req_op == OP_GET) ? req_max_len : req_msg_length;
      classified.data = req_in_byte;
      classified.kind = CMD_GET;
      push            = start && !busy;
      unique case (req_op)
         OP_START: begin
            classified.kind = (req_msg_length > LEN_W'(MAX_MESSAGE)) ? CMD_REJECT : CMD_START;
         end
         OP_BYTE: begin
            classified.kind = CMD_BYTE;
         end
         OP_GET: begin
            classified.kind = CMD_GET;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ===== design/vlmr_back.sv =====
module vlmr_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  vlmr_pkg::cmd_type           cmd,
   output logic                        cmd_pop,
   output logic                        ram_we,
   output logic [vlmr_pkg::PTR_W-1:0]  ram_waddr,
   output logic [vlmr_pkg::BYTE_W-1:0] ram_wdata,
   output logic [vlmr_pkg::PTR_W-1:0]  ram_raddr,
   input  logic [vlmr_pkg::BYTE_W-1:0] ram_rdata,
   output logic                        rsp_valid,
   output vlmr_pkg::rsp_type           rsp
);
   import vlmr_pkg::*;
   `include "assert_macros.svh"

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_HDR     = 2'd1;
   localparam logic [1:0] ST_GET_HDR = 2'd2;
   localparam logic [1:0] ST_STREAM  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [PTR_W-1:0]  cp_ff, cp_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic              open_ff, open_in;
   logic [LEN_W-1:0]  open_len_ff, open_len_in;
   logic [SEQ_W-1:0]  rseq_ff, rseq_in;
   logic [HIDX_W-1:0] hidx_ff, hidx_in;
   cmd_type           cur_ff, cur_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [PTR_W-1:0]  next_ff, next_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [PTR_W-1:0]  wp_step;
   logic [PTR_W-1:0]  body_addr;
   logic [CMP_W-1:0]  need;
   logic [CMP_W-1:0]  free_bytes;
   logic [LEN_W-1:0]  head_len;
   logic              stream_last;

   assign wp_step     = wrap_add(wp_ff, (PTR_W+1)'(1));
   assign body_addr   = wrap_add(rp_ff, (PTR_W+1)'(HEADER_BYTES));
   assign need        = CMP_W'(cmd.arg) + CMP_W'(HEADER_BYTES);
   assign free_bytes  = CMP_W'(USED_W'(BUFFER_BYTES) - used_ff);
   assign head_len    = (ram_rdata > BYTE_W'(MAX_MESSAGE)) ? LEN_W'(MAX_MESSAGE)
                                                          : ram_rdata[LEN_W-1:0];
   assign stream_last = (cnt_ff == len_ff - LEN_W'(1));

   always_comb begin
      state_in     = state_ff;
      rp_in        = rp_ff;
      cp_in        = cp_ff;
      wp_in        = wp_ff;
      used_in      = used_ff;
      rem_in       = rem_ff;
      open_in      = open_ff;
      open_len_in  = open_len_ff;
      rseq_in      = rseq_ff;
      hidx_in      = hidx_ff;
      cur_in       = cur_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      next_in      = next_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.last  = 1'b1;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = wp_ff;
      ram_wdata    = '0;
      ram_raddr    = rp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               unique case (cmd.kind)
                  CMD_REJECT: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = STAT_NO_SPACE;
                  end
                  CMD_START: begin
                     if (need > free_bytes) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STAT_NO_SPACE;
                     end else begin
                        wp_in    = cp_ff;
                        hidx_in  = '0;
                        state_in = ST_HDR;
                     end
                  end
                  CMD_BYTE: begin
                     rsp_valid_in = 1'b1;
                     if (!open_ff) begin
                        rsp_in.status = STAT_NO_OPEN;
                     end else begin
                        rsp_in.status = STAT_OK;
                        ram_we        = 1'b1;
                        ram_wdata     = cmd.data;
                        wp_in         = wp_step;
                        if (rem_ff == LEN_W'(1)) begin
                           used_in = used_ff + USED_W'(open_len_ff) + USED_W'(HEADER_BYTES);
                           cp_in   = wp_step;
                           open_in = 1'b0;
                           rem_in  = '0;
                        end else begin
                           rem_in = rem_ff - LEN_W'(1);
                        end
                     end
                  end
                  default: begin
                     if (used_ff < USED_W'(HEADER_BYTES)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STAT_EMPTY;
                     end else begin
                        ram_raddr = rp_ff;
                        state_in  = ST_GET_HDR;
                     end
                  end
               endcase
            end
         end
         ST_HDR: begin
            ram_we    = 1'b1;
            ram_wdata = (hidx_ff == '0) ? BYTE_W'(cur_ff.arg) : '0;
            wp_in     = wp_step;
            hidx_in   = hidx_ff + HIDX_W'(1);
            if (hidx_ff == HIDX_W'(HEADER_BYTES - 1)) begin
               open_in       = 1'b1;
               rem_in        = cur_ff.arg;
               open_len_in   = cur_ff.arg;
               rsp_valid_in  = 1'b1;
               rsp_in.status = STAT_OK;
               state_in      = ST_IDLE;
               if (cur_ff.arg == '0) begin
                  used_in = used_ff + USED_W'(HEADER_BYTES);
                  cp_in   = wp_step;
                  open_in = 1'b0;
               end
            end
         end
         ST_GET_HDR: begin
            rsp_in.head_length = head_len;
            rsp_in.msg_seq     = rseq_ff;
            if (head_len > cur_ff.arg) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STAT_TOO_LONG;
               state_in      = ST_IDLE;
            end else if (head_len == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STAT_OK;
               rp_in         = body_addr;
               used_in       = used_ff - USED_W'(HEADER_BYTES);
               rseq_in       = rseq_ff + SEQ_W'(1);
               state_in      = ST_IDLE;
            end else begin
               ram_raddr = body_addr;
               next_in   = wrap_add(body_addr, (PTR_W+1)'(1));
               len_in    = head_len;
               cnt_in    = '0;
               state_in  = ST_STREAM;
            end
         end
         default: begin
            rsp_valid_in       = 1'b1;
            rsp_in.status      = STAT_OK;
            rsp_in.out_byte    = ram_rdata;
            rsp_in.byte_valid  = 1'b1;
            rsp_in.last        = stream_last;
            rsp_in.head_length = len_ff;
            rsp_in.msg_seq     = rseq_ff;
            ram_raddr          = next_ff;
            next_in            = wrap_add(next_ff, (PTR_W+1)'(1));
            cnt_in             = cnt_ff + LEN_W'(1);
            if (stream_last) begin
               rp_in    = wrap_add(rp_ff,
                             (PTR_W+1)'(ADV_W'(len_ff) + ADV_W'(HEADER_BYTES)));
               used_in  = used_ff - USED_W'(len_ff) - USED_W'(HEADER_BYTES);
               rseq_in  = rseq_ff + SEQ_W'(1);
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rp_ff        <= '0;
         cp_ff        <= '0;
         wp_ff        <= '0;
         used_ff      <= '0;
         rem_ff       <= '0;
         open_ff      <= 1'b0;
         rseq_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         cp_ff        <= cp_in;
         wp_ff        <= wp_in;
         used_ff      <= used_in;
         rem_ff       <= rem_in;
         open_ff      <= open_in;
         rseq_ff      <= rseq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      open_len_ff <= open_len_in;
      hidx_ff     <= hidx_in;
      cur_ff      <= cur_in;
      len_ff      <= len_in;
      cnt_ff      <= cnt_in;
      next_ff     <= next_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `ASSERT_NOW(a_byte_ok, clock, reset, rsp_valid_ff && rsp_ff.byte_valid,
      rsp_ff.status == STAT_OK, "payload byte with non-ok status")
   `ASSERT_NOW(a_used_bound, clock, reset, 1'b1,
      used_ff <= USED_W'(BUFFER_BYTES), "committed bytes exceed ring size")
   `ASSERT_NOW(a_stream_count, clock, reset, state_ff == ST_STREAM,
      cnt_ff < len_ff, "stream count past message length")
   `ASSERT_NEXT(a_stream_emit, clock, reset, state_ff == ST_STREAM,
      rsp_valid_ff && rsp_ff.byte_valid, "stream cycle without payload byte")

endmodule

// ===== design/variable_length_message_ring_core.sv =====
// Framed message ring. Requests enter on start/busy: a request is taken at a
// clock edge with start high and busy low. req_op selects put-start (length in
// req_msg_length), put-byte (req_in_byte) or get (limit in req_max_len); op 3
// is dropped without a response. Responses leave on rsp_valid, one cycle per
// response, and must be taken when shown: the receiver cannot stall.
// A two-entry request queue sits ahead of the executing back end, so busy
// rises only while the queue is full.
// From the accepting edge with the back end idle, a request passes the queue;
// put-byte, no_space and empty responses then leave via the response register;
// a put-start holds the back end for its header writes (one ring write per
// header byte) and responds as the last is written; a get reads the header,
// then shows too_long and zero-length responses, or the first payload byte and
// then one payload byte per cycle. Sustained rate: one put-byte per cycle, one
// get byte per cycle, set by the single ring RAM write and read port.
// Reset (synchronous, active high) empties the queue, clears the ring pointers,
// used and remaining counts, sequence and open message; the ring is not cleared.
module variable_length_message_ring_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [vlmr_pkg::OP_W-1:0]     req_op,
   input  logic [vlmr_pkg::LEN_W-1:0]    req_msg_length,
   input  logic [vlmr_pkg::BYTE_W-1:0]   req_in_byte,
   input  logic [vlmr_pkg::LEN_W-1:0]    req_max_len,
   output logic                          rsp_valid,
   output logic [vlmr_pkg::STAT_W-1:0]   rsp_status,
   output logic [vlmr_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_last,
   output logic [vlmr_pkg::LEN_W-1:0]    rsp_head_length,
   output logic [vlmr_pkg::SEQ_W-1:0]    rsp_msg_seq
);
   import vlmr_pkg::*;

   logic              cmd_valid;
   cmd_type           cmd;
   logic              cmd_pop;
   logic              ram_we;
   logic [PTR_W-1:0]  ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic [PTR_W-1:0]  ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;
   rsp_type           rsp;

   vlmr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_msg_length (req_msg_length),
      .req_in_byte    (req_in_byte),
      .req_max_len    (req_max_len),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   vlmr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   vlmr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_BYTES)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_status      = rsp.status;
   assign rsp_out_byte    = rsp.out_byte;
   assign rsp_byte_valid  = rsp.byte_valid;
   assign rsp_last        = rsp.last;
   assign rsp_head_length = rsp.head_length;
   assign rsp_msg_seq     = rsp.msg_seq;

endmodule

// ===== tb/variable_length_message_ring_core_test.sv =====
module variable_length_message_ring_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import vlmr_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int TOTAL_ITEMS  = 130;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 24;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [LEN_W-1:0]  msg_length;
      logic [BYTE_W-1:0] in_byte;
      logic [LEN_W-1:0]  max_len;
      int                gap_pct;
      bit                drain;
   } ring_request_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_op = '0;
   logic [LEN_W-1:0]    req_msg_length = '0;
   logic [BYTE_W-1:0]   req_in_byte = '0;
   logic [LEN_W-1:0]    req_max_len = '0;
   logic                rsp_valid;
   logic [STAT_W-1:0]   rsp_status;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_byte_valid;
   logic                rsp_last;
   logic [LEN_W-1:0]    rsp_head_length;
   logic [SEQ_W-1:0]    rsp_msg_seq;

   ring_request_type req_backlog[$];
   ring_request_type in_flight;
   rsp_type          due_rsp[$];
   rsp_type          seen;
   rsp_type          want;

   logic [BYTE_W-1:0] ring_mem [BUFFER_BYTES];
   int                rd_ptr = 0;
   int                commit_ptr = 0;
   int                wr_pos = 0;
   int                used_bytes = 0;
   int                left_bytes = 0;
   bit                msg_open = 1'b0;
   logic [SEQ_W-1:0]  rd_seq = '0;

   int  fault_count = 0;
   int  accepted_count = 0;
   int  checked_count = 0;
   int  stall_cycles = 0;
   int  live_items = 0;
   bit  hold_next = 1'b0;
   bit  timed_out = 1'b0;

   variable_length_message_ring_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_msg_length  (req_msg_length),
      .req_in_byte     (req_in_byte),
      .req_max_len     (req_max_len),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last        (rsp_last),
      .rsp_head_length (rsp_head_length),
      .rsp_msg_seq     (rsp_msg_seq)
   );

   always #5 clock = ~clock;

   function automatic void post_rsp(input logic [STAT_W-1:0] status,
                                    input logic [BYTE_W-1:0] data,
                                    input logic valid, input logic last,
                                    input logic [LEN_W-1:0] hlen,
                                    input logic [SEQ_W-1:0] seq);
      rsp_type r;
      r.status      = status;
      r.out_byte    = data;
      r.byte_valid  = valid;
      r.last        = last;
      r.head_length = hlen;
      r.msg_seq     = seq;
      due_rsp.push_back(r);
   endfunction

   function automatic void close_frame();
      used_bytes += int'(ring_mem[commit_ptr]) + HEADER_BYTES;
      commit_ptr = wr_pos;
      msg_open   = 1'b0;
      left_bytes = 0;
   endfunction

   function automatic void apply_to_ring(input ring_request_type r);
      int len;
      int p;
      case (r.op)
         OP_START: begin
            if (int'(r.msg_length) > MAX_MESSAGE ||
                int'(r.msg_length) + HEADER_BYTES > BUFFER_BYTES - used_bytes) begin
               post_rsp(STAT_NO_SPACE, '0, 1'b0, 1'b1, '0, '0);
            end else begin
               wr_pos = commit_ptr;
               for (int i = 0; i < HEADER_BYTES; i++) begin
                  ring_mem[wr_pos] = (i == 0) ? {1'b0, r.msg_length} : '0;
                  wr_pos = (wr_pos + 1) % BUFFER_BYTES;
               end
               msg_open   = 1'b1;
               left_bytes = int'(r.msg_length);
               if (left_bytes == 0) close_frame();
               post_rsp(STAT_OK, '0, 1'b0, 1'b1, '0, '0);
            end
         end
         OP_BYTE: begin
            if (!msg_open) begin
               post_rsp(STAT_NO_OPEN, '0, 1'b0, 1'b1, '0, '0);
            end else begin
               ring_mem[wr_pos] = r.in_byte;
               wr_pos = (wr_pos + 1) % BUFFER_BYTES;
               left_bytes--;
               if (left_bytes == 0) close_frame();
               post_rsp(STAT_OK, '0, 1'b0, 1'b1, '0, '0);
            end
         end
         OP_GET: begin
            if (used_bytes < HEADER_BYTES) begin
               post_rsp(STAT_EMPTY, '0, 1'b0, 1'b1, '0, '0);
            end else begin
               len = int'(ring_mem[rd_ptr]);
               if (len > MAX_MESSAGE) len = MAX_MESSAGE;
               if (len > int'(r.max_len)) begin
                  post_rsp(STAT_TOO_LONG, '0, 1'b0, 1'b1, LEN_W'(len), rd_seq);
               end else begin
                  p = (rd_ptr + HEADER_BYTES) % BUFFER_BYTES;
                  if (len == 0) post_rsp(STAT_OK, '0, 1'b0, 1'b1, '0, rd_seq);
                  for (int i = 0; i < len; i++) begin
                     post_rsp(STAT_OK, ring_mem[p], 1'b1, i == len - 1, LEN_W'(len),
                              rd_seq);
                     p = (p + 1) % BUFFER_BYTES;
                  end
                  rd_ptr = (rd_ptr + len + HEADER_BYTES) % BUFFER_BYTES;
                  used_bytes -= len + HEADER_BYTES;
                  rd_seq++;
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic add_req(input logic [OP_W-1:0] op, input int unsigned value);
      ring_request_type r;
      r.op         = op;
      r.msg_length = LEN_W'($urandom_range(0, 127));
      r.in_byte    = BYTE_W'($urandom_range(0, 255));
      r.max_len    = LEN_W'($urandom_range(0, 127));
      r.gap_pct    = 0;
      r.drain      = hold_next;
      hold_next    = 1'b0;
      case (op)
         OP_START: r.msg_length = LEN_W'(value);
         OP_BYTE:  r.in_byte = BYTE_W'(value);
         OP_GET:   r.max_len = LEN_W'(value);
         default: ;
      endcase
      if (op != OP_UNUSED) live_items++;
      req_backlog.push_back(r);
   endtask

   task automatic add_message(input int len);
      add_req(OP_START, len);
      repeat (len) add_req(OP_BYTE, $urandom_range(0, 255));
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_to_ring(in_flight);
            accepted_count++;
         end
         if (!start || !busy) begin
            if (req_backlog.size() != 0 &&
                !(req_backlog[0].drain && (due_rsp.size() != 0 || rsp_valid)) &&
                $urandom_range(0, 99) >= req_backlog[0].gap_pct) begin
               in_flight = req_backlog.pop_front();
               start          <= 1'b1;
               req_op         <= in_flight.op;
               req_msg_length <= in_flight.msg_length;
               req_in_byte    <= in_flight.in_byte;
               req_max_len    <= in_flight.max_len;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         seen = {rsp_status, rsp_out_byte, rsp_byte_valid, rsp_last,
                 rsp_head_length, rsp_msg_seq};
         if (due_rsp.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("unexpected response: st=%0d byte=%02h bv=%0b last=%0b %s",
                        seen.status, seen.out_byte, seen.byte_valid, seen.last,
                        $sformatf("len=%0d seq=%0d", seen.head_length, seen.msg_seq));
         end else begin
            want = due_rsp.pop_front();
            checked_count++;
            if (seen.status !== want.status || seen.out_byte !== want.out_byte ||
                seen.byte_valid !== want.byte_valid || seen.last !== want.last ||
                seen.head_length !== want.head_length || seen.msg_seq !== want.msg_seq) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT) begin
                  $display("response %0d mismatch:", checked_count);
                  $display("  want st=%0d byte=%02h bv=%0b last=%0b len=%0d seq=%0d",
                           want.status, want.out_byte, want.byte_valid,
                           want.last, want.head_length, want.msg_seq);
                  $display("  got  st=%0d byte=%02h bv=%0b last=%0b len=%0d seq=%0d",
                           seen.status, seen.out_byte, seen.byte_valid, seen.last,
                           seen.head_length, seen.msg_seq);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      int pick;
      int len;
      int sel;
      int n;
      bit mid_hold;

      mid_hold = 1'b0;

      add_req(OP_GET, 0);
      add_req(OP_BYTE, 8'hFF);
      add_req(OP_UNUSED, 0);
      add_req(OP_START, 127);
      add_req(OP_START, MAX_MESSAGE + 1);
      add_req(OP_START, 0);
      add_req(OP_GET, 0);
      add_req(OP_START, 3);
      add_req(OP_BYTE, 8'h00);
      add_req(OP_BYTE, 8'hFF);
      add_req(OP_BYTE, 8'hA5);
      add_req(OP_GET, 2);
      add_req(OP_GET, 127);
      add_req(OP_START, 5);
      add_req(OP_BYTE, 8'h01);
      add_req(OP_BYTE, 8'h02);
      add_req(OP_START, 2);
      add_req(OP_BYTE, 8'h5A);
      add_req(OP_BYTE, 8'hC3);
      add_req(OP_BYTE, 8'h11);
      add_req(OP_GET, MAX_MESSAGE);
      add_req(OP_GET, MAX_MESSAGE);

      hold_next  = 1'b1;
      while (live_items < TOTAL_ITEMS) begin
         if (!mid_hold && live_items >= TOTAL_ITEMS / 2) begin
            hold_next = 1'b1;
            mid_hold  = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            sel = $urandom_range(0, 9);
            len = (sel < 7) ? $urandom_range(0, 12) :
                  (sel < 9) ? $urandom_range(13, MAX_MESSAGE - 1) : MAX_MESSAGE;
            if (len > TOTAL_ITEMS - live_items) len = TOTAL_ITEMS - live_items;
            add_message(len);
         end else if (pick < 80) begin
            if ($urandom_range(0, 3) == 0) add_req(OP_GET, $urandom_range(0, 20));
            else add_req(OP_GET, $urandom_range(MAX_MESSAGE, 127));
         end else if (pick < 88) begin
            len = $urandom_range(2, 20);
            add_req(OP_START, len);
            repeat ($urandom_range(1, len - 1)) add_req(OP_BYTE, $urandom_range(0, 255));
         end else if (pick < 94) begin
            add_req(OP_BYTE, $urandom_range(0, 255));
         end else if (pick < 97) begin
            add_req(OP_START, $urandom_range(MAX_MESSAGE + 1, 127));
         end else begin
            add_req(OP_UNUSED, 0);
         end
      end

      n = req_backlog.size();
      foreach (req_backlog[i])
         req_backlog[i].gap_pct = (i < n / 3) ? 16 : (i < 2 * n / 3) ? 55 : 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (!timed_out && (req_backlog.size() != 0 || start || due_rsp.size() != 0)) begin
         @(negedge clock);
         timed_out = (stall_cycles >= STALL_LIMIT);
      end
      if (!timed_out) repeat (TAIL_CYCLES) @(negedge clock);
      fault_count += due_rsp.size();

      $display("ring run: %0d requests taken, %0d responses checked", accepted_count,
               checked_count);
      $display("covered puts, streamed gets, restarts, too-long, empty, oversize starts");
      if (!timed_out && fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
